// ===== hdl/acws_pkg.sv =====
// ----------------------------------------------------------------------------
// acws_pkg
// Shared types and constants of the escape-aware column window slicer.
// ----------------------------------------------------------------------------
package acws_pkg;

   // Default sizing
   localparam int MAX_WIDTH_DEF   = 56;
   localparam int COLUMN_BITS_DEF = 16;

   // Register index, taken from paddr[3:2]
   localparam logic [1:0] REG_START_COL    = 2'd0;
   localparam logic [1:0] REG_WINDOW_WIDTH = 2'd1;
   localparam logic [1:0] REG_ADD_RESET    = 2'd2;

   // Byte codes
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_PARAM_HI = 8'h3F;
   localparam logic [7:0] CH_INTER_HI = 8'h2F;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_FINAL_HI = 8'h7E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOWER_M = 8'h6D;

   // Position inside the current unit
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_ESC1      = 3'd1,
      PH_CSI_PARAM = 3'd2,
      PH_CSI_INTER = 3'd3,
      PH_OSC       = 3'd4,
      PH_OSC_ESC   = 3'd5,
      PH_CONT      = 3'd6
   } phase_type;

endpackage

// ===== hdl/ansi_column_window_slicer_top.sv =====
// ----------------------------------------------------------------------------
// ansi_column_window_slicer_top
// Escape-aware column window slice of a byte stream, with padding and an
// optional trailing attribute reset.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_has_byte, req_in_byte, req_is_last
//  rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_out_last
//  csr      in         APB, pready tied high window start @0, window_width @4, add_reset @8
//
//  An input beat is scanned in the cycle it is accepted; the scanner state and
//  a result job register update at that edge. A job holds up to one passed
//  byte, the padding count and the reset sequence, and drains one beat per
//  cycle while rsp is not stalled; the req side waits until the job has
//  drained, and an item with no result beats does not hold it. The job register
//  drains while the next beat is accepted in the cycle of its final beat.
//  Reset clears scanner state, the job register and the registers to their
//  reset values. A stall on rsp holds the job and, once it is full, the req side.
// ----------------------------------------------------------------------------
module ansi_column_window_slicer_top
   import acws_pkg::*;
#(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_byte,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_last,
   // result beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int          PAD_BITS = $clog2(MAX_WIDTH + 1);
   localparam int          CMP_BITS = (COLUMN_BITS > 13) ? COLUMN_BITS : 13;
   localparam logic [5:0]  MAX_W    = 6'(MAX_WIDTH);

   // ---------------- registers ----------------
   logic [11:0] win_first_ff;
   logic [5:0]  window_width_ff;
   logic        add_reset_ff;

   // Write lands at the access phase; every access completes at once.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_first_ff    <= 12'd0;
         window_width_ff <= 6'd1;
         add_reset_ff    <= 1'b1;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_START_COL:    win_first_ff    <= pwdata[11:0];
            REG_WINDOW_WIDTH: window_width_ff <= pwdata[5:0];
            REG_ADD_RESET:    add_reset_ff    <= pwdata[0];
            default: ;  // writes past the list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_START_COL:    prdata = {20'd0, win_first_ff};
         REG_WINDOW_WIDTH: prdata = {26'd0, window_width_ff};
         REG_ADD_RESET:    prdata = {31'd0, add_reset_ff};
         default:          prdata = 32'd0;
      endcase
   end

   // ---------------- scanner state ----------------
   phase_type              phase_ff, phase_in;
   logic [1:0]             cont_left_ff, cont_left_in;
   logic                   copy_unit_ff, copy_unit_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [6:0]             cols_copied_ff, cols_copied_in;
   logic                   window_done_ff, window_done_in;

   // ---------------- result job ----------------
   logic                   job_valid_ff, job_valid_in;
   logic                   job_has_ff, job_has_in;
   logic [7:0]             job_byte_ff, job_byte_in;
   logic [PAD_BITS-1:0]    job_pad_ff, job_pad_in;
   logic [2:0]             job_rst_ff, job_rst_in;
   logic                   job_last_ff, job_last_in;

   logic                   job_final;   // the beat on show is the job's last
   logic                   req_fire;
   logic                   rsp_fire;

   // Effective window width, clamped to the build limit.
   logic [5:0]             eff_w;
   logic                   take;
   logic                   emit;
   logic                   start;
   logic [7:0]             b;

   // start-of-unit helpers
   logic [CMP_BITS-1:0]    col_x, start_x, win_end;
   logic                   col_hit;
   logic [1:0]             ncols;
   logic [1:0]             extra_bytes;
   logic                   pass;
   logic [COLUMN_BITS:0]   col_sum;
   logic [7:0]             cols_sum;
   logic [PAD_BITS-1:0]    pad_count;
   logic                   has_tail;

   assign b       = req_in_byte;
   assign eff_w   = (window_width_ff > MAX_W) ? MAX_W : window_width_ff;
   assign take    = req_has_byte && !window_done_ff && (eff_w != 6'd0);

   assign col_x   = CMP_BITS'(column_ff);
   assign start_x = CMP_BITS'(win_first_ff);
   assign win_end = CMP_BITS'({1'b0, win_first_ff} + {7'd0, eff_w});
   assign col_hit = (col_x >= start_x) && (col_x < win_end);

   // Lead byte sets the character size; anything else is a stray byte.
   always_comb begin
      priority if (!b[7]) begin
         extra_bytes = 2'd0; ncols = 2'd1;
      end else if (b[7:5] == 3'b110) begin
         extra_bytes = 2'd1; ncols = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         extra_bytes = 2'd2; ncols = 2'd1;
      end else if (b[7:3] == 5'b11110) begin
         extra_bytes = 2'd3; ncols = 2'd2;
      end else begin
         extra_bytes = 2'd0; ncols = 2'd0;
      end
   end

   assign pass     = (ncols == 2'd0) || col_hit;
   assign col_sum  = {1'b0, column_ff} + (COLUMN_BITS+1)'(ncols);
   assign cols_sum = {1'b0, cols_copied_ff} + {6'd0, ncols};

   always_comb begin
      phase_in       = phase_ff;
      cont_left_in   = cont_left_ff;
      copy_unit_in   = copy_unit_ff;
      column_in      = column_ff;
      cols_copied_in = cols_copied_ff;
      window_done_in = window_done_ff;
      emit           = 1'b0;
      start          = 1'b0;

      if (take) begin
         unique case (phase_ff)
            PH_CONT: begin
               // Continuation bytes count down whatever their value.
               emit         = copy_unit_ff;
               cont_left_in = cont_left_ff - 2'd1;
               if (cont_left_in == 2'd0) phase_in = PH_IDLE;
            end
            PH_ESC1: begin
               emit = 1'b1;
               priority if (b == CH_LBRACK) phase_in = PH_CSI_PARAM;
               else if (b == CH_RBRACK)     phase_in = PH_OSC;
               else                         phase_in = PH_IDLE;
            end
            PH_CSI_PARAM, PH_CSI_INTER: begin
               priority if (phase_ff == PH_CSI_PARAM && b >= CH_ZERO
                            && b <= CH_PARAM_HI) begin
                  emit = 1'b1;
               end else if (b >= CH_SPACE && b <= CH_INTER_HI) begin
                  emit     = 1'b1;
                  phase_in = PH_CSI_INTER;
               end else if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  // Byte outside CSI classes closes it and opens a new unit.
                  phase_in = PH_IDLE;
                  start    = 1'b1;
               end
            end
            PH_OSC_ESC: begin
               emit = 1'b1;
               priority if (b == CH_BSLASH) phase_in = PH_IDLE;
               else if (b == CH_BEL)        phase_in = PH_IDLE;
               else if (b == CH_ESC)        phase_in = PH_OSC_ESC;
               else                         phase_in = PH_OSC;
            end
            PH_OSC: begin
               emit = 1'b1;
               priority if (b == CH_BEL) phase_in = PH_IDLE;
               else if (b == CH_ESC)     phase_in = PH_OSC_ESC;
               else                      phase_in = PH_OSC;
            end
            default: begin
               phase_in = PH_IDLE;
               start    = 1'b1;
            end
         endcase

         if (start) begin
            priority if (col_x >= win_end) begin
               window_done_in = 1'b1;
            end else if (b == CH_ESC) begin
               emit         = 1'b1;
               copy_unit_in = 1'b1;
               phase_in     = PH_ESC1;
            end else begin
               emit = pass;
               if (pass) cols_copied_in = cols_sum[7] ? 7'd127 : cols_sum[6:0];
               column_in = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
               if (extra_bytes != 2'd0) begin
                  cont_left_in = extra_bytes;
                  copy_unit_in = pass;
                  phase_in     = PH_CONT;
               end
            end
         end
      end

      // End of string: drop all scanner state.
      if (req_is_last) begin
         phase_in       = PH_IDLE;
         cont_left_in   = 2'd0;
         copy_unit_in   = 1'b0;
         column_in      = '0;
         cols_copied_in = 7'd0;
         window_done_in = 1'b0;
      end
   end

   // Padding uses the column count after this beat's byte.
   always_comb begin
      logic [6:0] cc;
      cc = cols_copied_in;
      if (req_is_last) cc = (emit && start) ? (cols_sum[7] ? 7'd127 : cols_sum[6:0])
                                            : cols_copied_ff;
      if (req_is_last && !(emit && start && ncols != 2'd0 && b != CH_ESC))
         cc = cols_copied_ff;
      pad_count = (cc < {1'b0, eff_w}) ? PAD_BITS'({1'b0, eff_w} - cc) : '0;
   end

   assign has_tail = req_is_last && (eff_w != 6'd0)
                     && ((pad_count != '0) || add_reset_ff);

   // ---------------- job drain ----------------
   assign job_final = (job_has_ff && job_pad_ff == '0 && job_rst_ff == 3'd0)
                   || (!job_has_ff && job_pad_ff == PAD_BITS'(1) && job_rst_ff == 3'd0)
                   || (!job_has_ff && job_pad_ff == '0 && job_rst_ff == 3'd1);

   assign rsp_valid = job_valid_ff;
   assign rsp_fire  = job_valid_ff && !rsp_stall;
   assign req_stall = job_valid_ff && !(job_final && !rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      if (job_has_ff) begin
         rsp_out_byte = job_byte_ff;
      end else if (job_pad_ff != '0) begin
         rsp_out_byte = CH_SPACE;
      end else begin
         unique case (job_rst_ff)
            3'd4:    rsp_out_byte = CH_ESC;
            3'd3:    rsp_out_byte = CH_LBRACK;
            3'd2:    rsp_out_byte = CH_ZERO;
            default: rsp_out_byte = CH_LOWER_M;
         endcase
      end
   end
   assign rsp_out_last = job_last_ff && job_final;

   always_comb begin
      job_valid_in = job_valid_ff;
      job_has_in   = job_has_ff;
      job_byte_in  = job_byte_ff;
      job_pad_in   = job_pad_ff;
      job_rst_in   = job_rst_ff;
      job_last_in  = job_last_ff;

      // Advance one beat.
      if (rsp_fire) begin
         priority if (job_has_ff)    job_has_in = 1'b0;
         else if (job_pad_ff != '0)  job_pad_in = job_pad_ff - PAD_BITS'(1);
         else                        job_rst_in = job_rst_ff - 3'd1;
         if (job_final) job_valid_in = 1'b0;
      end

      // Load a fresh job when the accepted beat yields anything.
      if (req_fire && (emit || has_tail)) begin
         job_valid_in = 1'b1;
         job_has_in   = emit;
         job_byte_in  = b;
         job_pad_in   = has_tail ? pad_count : '0;
         job_rst_in   = (has_tail && add_reset_ff) ? 3'd4 : 3'd0;
         job_last_in  = req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         cont_left_ff   <= 2'd0;
         copy_unit_ff   <= 1'b0;
         column_ff      <= '0;
         cols_copied_ff <= 7'd0;
         window_done_ff <= 1'b0;
         job_valid_ff   <= 1'b0;
         job_has_ff     <= 1'b0;
         job_pad_ff     <= '0;
         job_rst_ff     <= 3'd0;
         job_last_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff       <= phase_in;
            cont_left_ff   <= cont_left_in;
            copy_unit_ff   <= copy_unit_in;
            column_ff      <= column_in;
            cols_copied_ff <= cols_copied_in;
            window_done_ff <= window_done_in;
         end
         job_valid_ff <= job_valid_in;
         job_has_ff   <= job_has_in;
         job_pad_ff   <= job_pad_in;
         job_rst_ff   <= job_rst_in;
         job_last_ff  <= job_last_in;
      end
   end

   // Payload byte: no reset needed.
   always_ff @(posedge clock) begin
      job_byte_ff <= job_byte_in;
   end

endmodule

// ===== hdl/acws_checker.sv =====
// ----------------------------------------------------------------------------
// acws_checker
// Port-level checks of the column window slicer, bound to its top level.
// ----------------------------------------------------------------------------
module acws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_has_byte,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_out_last
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)
                                    && $stable(rsp_out_last)))
      else $error("stalled result beat changed");

   // The input side stalls only behind pending result beats.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with nothing pending");

   // The final beat of a string drains the block unless a new beat enters.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_out_last && !(req_valid && !req_stall))
      |=> !rsp_valid)
      else $error("result beat after end of string");

   // An empty beat into an idle block yields nothing.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_has_byte && !req_is_last && !rsp_valid)
      |=> !rsp_valid)
      else $error("empty input beat produced a result");

endmodule

bind ansi_column_window_slicer_top acws_checker u_acws_checker (.*);
